// ===== sv/dri_pkg.sv =====
// Shared types and constants for the dead-reckoning pose integrator.
// Holds the control word layout, the CORDIC constants and the arctangent table.
// No dependencies.
`default_nettype none

package dri_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int CordicIters = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
  localparam int IterW       = (CordicIters > 1) ? $clog2(CordicIters) : 1;
  localparam int PcW         = 4;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [1:0] {
    MA_V,
    MA_W,
    MA_D
  } mul_a_sel_e;

  typedef enum logic [2:0] {
    MB_DT,
    MB_CLO,
    MB_CHI,
    MB_SLO,
    MB_SHI
  } mul_b_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_LOOP,
    JC_WAIT_OUT,
    JC_GOTO
  } jump_e;

  typedef struct packed {
    logic       take_in;
    logic       mul_en;
    mul_a_sel_e mul_a;
    mul_b_sel_e mul_b;
    logic       d_load;
    logic       turn_en;
    logic       cordic_iter;
    logic       cordic_fix;
    acc_op_e    acc_op;
    logic       wr_x;
    logic       wr_y;
    logic       wr_h;
    logic       emit;
    jump_e      jump;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic iter_last;
  } stat_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turn(logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dri_sequencer.sv =====
// Microcode sequencer: step counter, control store and jump logic.
// Depends on dri_pkg for the control word and status types.
`default_nettype none

module dri_sequencer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dri_pkg::stat_t stat_i,
  output dri_pkg::ctrl_t     ctrl_o,
  output logic               fire_o
);

  localparam logic [dri_pkg::PcW-1:0] PcWaitIn = 4'd0;
  localparam logic [dri_pkg::PcW-1:0] PcCordic = 4'd4;

  logic [dri_pkg::PcW-1:0] pc_q, pc_d;
  dri_pkg::ctrl_t cw;

  always_comb begin
    cw        = '0;
    cw.mul_a  = dri_pkg::MA_V;
    cw.mul_b  = dri_pkg::MB_DT;
    cw.acc_op = dri_pkg::ACC_NONE;
    cw.jump   = dri_pkg::JC_NEXT;
    cw.target = PcWaitIn;
    unique case (pc_q)
      4'd0: begin
        cw.take_in = 1'b1;
        cw.jump    = dri_pkg::JC_WAIT_IN;
      end
      4'd1: begin
        cw.mul_en = 1'b1;
      end
      4'd2: begin
        cw.mul_en = 1'b1;
        cw.mul_a  = dri_pkg::MA_W;
        cw.d_load = 1'b1;
      end
      4'd3: begin
        cw.turn_en = 1'b1;
      end
      4'd4: begin
        cw.cordic_iter = 1'b1;
        cw.jump        = dri_pkg::JC_LOOP;
        cw.target      = PcCordic;
      end
      4'd5: begin
        cw.cordic_fix = 1'b1;
      end
      4'd6: begin
        cw.mul_en = 1'b1;
        cw.mul_a  = dri_pkg::MA_D;
        cw.mul_b  = dri_pkg::MB_CLO;
      end
      4'd7: begin
        cw.mul_en = 1'b1;
        cw.mul_a  = dri_pkg::MA_D;
        cw.mul_b  = dri_pkg::MB_CHI;
        cw.acc_op = dri_pkg::ACC_LOAD;
      end
      4'd8: begin
        cw.mul_en = 1'b1;
        cw.mul_a  = dri_pkg::MA_D;
        cw.mul_b  = dri_pkg::MB_SLO;
        cw.acc_op = dri_pkg::ACC_ADD_HI;
      end
      4'd9: begin
        cw.mul_en = 1'b1;
        cw.mul_a  = dri_pkg::MA_D;
        cw.mul_b  = dri_pkg::MB_SHI;
        cw.acc_op = dri_pkg::ACC_LOAD;
        cw.wr_x   = 1'b1;
      end
      4'd10: begin
        cw.acc_op = dri_pkg::ACC_ADD_HI;
      end
      4'd11: begin
        cw.wr_y = 1'b1;
        cw.wr_h = 1'b1;
      end
      4'd12: begin
        cw.emit   = 1'b1;
        cw.jump   = dri_pkg::JC_WAIT_OUT;
        cw.target = PcWaitIn;
      end
      default: begin
        cw.jump   = dri_pkg::JC_GOTO;
        cw.target = PcWaitIn;
      end
    endcase
  end

  always_comb begin
    fire_o = 1'b1;
    pc_d   = pc_q + 1'b1;
    unique case (cw.jump)
      dri_pkg::JC_NEXT: begin
        pc_d = pc_q + 1'b1;
      end
      dri_pkg::JC_WAIT_IN: begin
        fire_o = stat_i.in_valid;
        pc_d   = stat_i.in_valid ? pc_q + 1'b1 : pc_q;
      end
      dri_pkg::JC_LOOP: begin
        pc_d = stat_i.iter_last ? pc_q + 1'b1 : cw.target;
      end
      dri_pkg::JC_WAIT_OUT: begin
        fire_o = stat_i.out_free;
        pc_d   = stat_i.out_free ? cw.target : pc_q;
      end
      dri_pkg::JC_GOTO: begin
        pc_d = cw.target;
      end
      default: begin
        pc_d = PcWaitIn;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcWaitIn;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = cw;

endmodule

`default_nettype wire

// ===== sv/dri_datapath.sv =====
// Datapath: input latches, shared multiplier, accumulator, CORDIC unit and pose.
// Driven by the dri_sequencer control word; depends on dri_pkg.
`default_nettype none

module dri_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dri_pkg::ctrl_t ctrl_i,
  input  wire logic           fire_i,
  input  wire logic [47:0]    in_data_i,
  output logic                iter_last_o,
  output logic [31:0]         pose_x_o,
  output logic [31:0]         pose_y_o,
  output logic [15:0]         pose_h_o
);

  logic signed [15:0] v_q, w_q;
  logic        [15:0] dt_q;
  logic signed [32:0] d_q;
  logic signed [49:0] prod_q, prod_d;
  logic signed [64:0] acc_q, acc_d;
  logic signed [64:0] rnd;
  logic        [31:0] delta;
  logic signed [33:0] x_q, y_q, z_q;
  logic signed [33:0] xs, ys, at;
  logic               flip_q, flip;
  logic [dri_pkg::IterW-1:0] iter_q;
  logic [31:0] pose_x_q, pose_y_q;
  logic [15:0] pose_h_q, head_new_q;
  logic [31:0] tsum;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic [15:0] h_in;

  // operand selection for the shared 33x17 multiplier
  always_comb begin
    case (ctrl_i.mul_a)
      dri_pkg::MA_V: mul_a = 33'(v_q);
      dri_pkg::MA_W: mul_a = 33'(w_q);
      dri_pkg::MA_D: mul_a = d_q;
      default:       mul_a = d_q;
    endcase
    case (ctrl_i.mul_b)
      dri_pkg::MB_DT:  mul_b = {1'b0, dt_q};
      dri_pkg::MB_CLO: mul_b = {1'b0, x_q[15:0]};
      dri_pkg::MB_CHI: mul_b = {x_q[31], x_q[31:16]};
      dri_pkg::MB_SLO: mul_b = {1'b0, y_q[15:0]};
      dri_pkg::MB_SHI: mul_b = {y_q[31], y_q[31:16]};
      default:         mul_b = {1'b0, dt_q};
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Q16.16 rounding, ties up
  assign rnd   = acc_q + (65'sd1 <<< 37);
  assign delta = {{5{rnd[64]}}, rnd[64:38]};

  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.acc_op)
      dri_pkg::ACC_LOAD:   acc_d = {{15{prod_q[49]}}, prod_q};
      dri_pkg::ACC_ADD_HI: acc_d = acc_q + {prod_q[48:0], 16'd0};
      default:             acc_d = acc_q;
    endcase
  end

  assign tsum = prod_q[31:0] + 32'h0000_8000;

  assign h_in = pose_h_q;
  assign flip = h_in[15] ^ h_in[14];
  assign xs   = x_q >>> iter_q;
  assign ys   = y_q >>> iter_q;
  assign at   = {2'b00, dri_pkg::atan_turn(5'(iter_q))};

  assign iter_last_o = (iter_q == dri_pkg::IterW'(dri_pkg::CordicIters - 1));

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      if (ctrl_i.take_in) begin
        v_q    <= in_data_i[15:0];
        w_q    <= in_data_i[31:16];
        dt_q   <= in_data_i[47:32];
        flip_q <= flip;
        x_q    <= dri_pkg::CordicGain;
        y_q    <= '0;
        z_q    <= {{3{h_in[15] ^ flip}}, h_in[14:0], 16'd0};
      end
      if (ctrl_i.mul_en) begin
        prod_q <= prod_d;
      end
      if (ctrl_i.d_load) begin
        d_q <= prod_q[32:0];
      end
      if (ctrl_i.turn_en) begin
        head_new_q <= pose_h_q - tsum[31:16];
      end
      acc_q <= acc_d;
      if (ctrl_i.cordic_iter) begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      if (ctrl_i.cordic_fix && flip_q) begin
        x_q <= -x_q;
        y_q <= -y_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q   <= '0;
      pose_x_q <= '0;
      pose_y_q <= '0;
      pose_h_q <= '0;
    end else if (fire_i) begin
      if (ctrl_i.take_in) begin
        iter_q <= '0;
      end else if (ctrl_i.cordic_iter) begin
        iter_q <= iter_q + 1'b1;
      end
      if (ctrl_i.wr_x) begin
        pose_x_q <= pose_x_q + delta;
      end
      if (ctrl_i.wr_y) begin
        pose_y_q <= pose_y_q + delta;
      end
      if (ctrl_i.wr_h) begin
        pose_h_q <= head_new_q;
      end
    end
  end

  assign pose_x_o = pose_x_q;
  assign pose_y_o = pose_y_q;
  assign pose_h_o = pose_h_q;

endmodule

`default_nettype wire

// ===== sv/dead_reckoning_pose_integrator.sv =====
// The CORDIC unit performs one rotation per cycle on the shared shift-add unit. An
// input word is accepted only while the sequencer waits for input, and the next
// word is taken once the microcode program has run through and returned there.
// A new input is taken while the previous result waits in the output register.
// Reset (async, active low) clears the pose to zero and the sequencer to idle.
// Top level: stream ports, output register; uses dri_sequencer, dri_datapath, dri_pkg.
`default_nettype none

module dead_reckoning_pose_integrator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [15:0] linear_velocity, [31:16] angular_velocity, [47:32] time_step
  input  wire logic [47:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [31:0] pos_x, [63:32] pos_y, [79:64] heading_angle
  output logic [79:0]      m_axis_tdata_o
);

  dri_pkg::ctrl_t ctrl;
  dri_pkg::stat_t stat;
  logic           fire;
  logic           iter_last;
  logic [31:0]    pose_x, pose_y;
  logic [15:0]    pose_h;
  logic           out_valid_q;
  logic [79:0]    out_data_q;

  assign stat.in_valid  = s_axis_tvalid_i;
  assign stat.out_free  = !out_valid_q || m_axis_tready_i;
  assign stat.iter_last = iter_last;

  dri_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .fire_o (fire)
  );

  dri_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .fire_i      (fire),
    .in_data_i   (s_axis_tdata_i),
    .iter_last_o (iter_last),
    .pose_x_o    (pose_x),
    .pose_y_o    (pose_y),
    .pose_h_o    (pose_h)
  );

  assign s_axis_tready_o = (ctrl.jump == dri_pkg::JC_WAIT_IN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && ctrl.emit) begin
      out_data_q <= {pose_h, pose_y, pose_x};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while a word is in flight");

  a_idle_after_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("sequencer not back at input wait after emitting");

  a_pose_held_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready_o && !s_axis_tvalid_i) |=> $stable(pose_x) && $stable(pose_h))
    else $error("pose changed while idle");

endmodule

`default_nettype wire
